// ===== rtl/ry420_pkg.sv =====
// Shared types, constants and arithmetic functions for the RGB to YCbCr 4:2:0 converter.
// Used by every module of the block except ry420_ram; depends on nothing else.
package ry420_pkg;

  localparam int unsigned WIDTH_LIMIT  = 8192;
  localparam int unsigned HEIGHT_LIMIT = 8192;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned CFG_W   = 14;
  localparam int unsigned COL_W   = 13;
  localparam int unsigned ROW_W   = 13;
  localparam int unsigned PLANE_W = 2;
  localparam int unsigned SUM_W   = PIX_W + 1;
  localparam int unsigned BLK_W   = PIX_W + 2;
  localparam int unsigned RGB_W   = 3 * PIX_W;

  localparam int unsigned LINE_DEPTH = WIDTH_LIMIT / 2;
  localparam int unsigned LINE_AW    = $clog2(LINE_DEPTH);
  localparam int unsigned LINE_W     = 3 * SUM_W;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  localparam logic [PLANE_W-1:0] PLANE_Y  = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_CB = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_CR = 2'd2;

  // One-hot result kinds, in emission order.
  localparam int unsigned KIND_W = 6;
  localparam logic [KIND_W-1:0] KIND_Y       = 6'b000001;
  localparam logic [KIND_W-1:0] KIND_Y_RIGHT = 6'b000010;
  localparam logic [KIND_W-1:0] KIND_Y_BELOW = 6'b000100;
  localparam logic [KIND_W-1:0] KIND_Y_DIAG  = 6'b001000;
  localparam logic [KIND_W-1:0] KIND_CB      = 6'b010000;
  localparam logic [KIND_W-1:0] KIND_CR      = 6'b100000;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] avg_r;
    logic [PIX_W-1:0] avg_g;
    logic [PIX_W-1:0] avg_b;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             pad_col;
    logic             pad_row;
    logic             chroma;
    logic             frame_end;
  } entry_t;

  function automatic logic [PIX_W-1:0] luma_of(input logic [PIX_W-1:0] r,
                                                input logic [PIX_W-1:0] g,
                                                input logic [PIX_W-1:0] b);
    logic [15:0] acc;
    acc = 16'd47 * 16'(r) + 16'd157 * 16'(g) + 16'd16 * 16'(b) + 16'd128;
    // The weighted sum never exceeds 219 after the shift, so no clamp is needed.
    return 8'd16 + acc[15:8];
  endfunction

  // Symmetric rounding division by 256, offset 128, clamp to 0..255.
  function automatic logic [PIX_W-1:0] chroma_round(input logic signed [17:0] v);
    logic [17:0]        mag;
    logic [9:0]         q;
    logic signed [10:0] res;
    mag = v[17] ? 18'(-v) : 18'(v);
    q   = 10'((mag + 18'd128) >> 8);
    res = v[17] ? (11'sd128 - $signed({1'b0, q})) : (11'sd128 + $signed({1'b0, q}));
    if (res < 11'sd0) begin
      return 8'd0;
    end else if (res > 11'sd255) begin
      return 8'd255;
    end
    return res[7:0];
  endfunction

  function automatic logic [PIX_W-1:0] cb_of(input logic [PIX_W-1:0] r,
                                              input logic [PIX_W-1:0] g,
                                              input logic [PIX_W-1:0] b);
    logic signed [17:0] v;
    v = 18'sd112 * $signed({10'd0, b}) - 18'sd26 * $signed({10'd0, r})
        - 18'sd87 * $signed({10'd0, g});
    return chroma_round(v);
  endfunction

  function automatic logic [PIX_W-1:0] cr_of(input logic [PIX_W-1:0] r,
                                              input logic [PIX_W-1:0] g,
                                              input logic [PIX_W-1:0] b);
    logic signed [17:0] v;
    v = 18'sd112 * $signed({10'd0, r}) - 18'sd102 * $signed({10'd0, g})
        - 18'sd10 * $signed({10'd0, b});
    return chroma_round(v);
  endfunction

endpackage

// ===== rtl/ry420_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the chroma pair-sum line store.
module ry420_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ry420_front.sv =====
// Front end: accepts pixels, tracks position, forms horizontal pair sums,
// keeps the line store and builds one queue entry per pixel.
// Depends on ry420_pkg and ry420_ram.
module ry420_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ry420_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ry420_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [ry420_pkg::PIX_W-1:0]        red_i,
  input  logic [ry420_pkg::PIX_W-1:0]        green_i,
  input  logic [ry420_pkg::PIX_W-1:0]        blue_i,
  input  logic                               full_i,
  output logic                               push_o,
  output ry420_pkg::entry_t                  entry_o
);

  localparam int unsigned PW = ry420_pkg::PIX_W;
  localparam int unsigned SW = ry420_pkg::SUM_W;
  localparam int unsigned BW = ry420_pkg::BLK_W;

  // Configuration, kept as last index and oddness of the effective size.
  logic [ry420_pkg::COL_W-1:0] w_last_q, w_last_d;
  logic [ry420_pkg::ROW_W-1:0] h_last_q, h_last_d;
  logic                        w_odd_q, w_odd_d, h_odd_q, h_odd_d;
  logic [ry420_pkg::CFG_W-1:0] eff;

  logic [ry420_pkg::COL_W-1:0] col_q, col_d;
  logic [ry420_pkg::ROW_W-1:0] row_q, row_d;
  logic [ry420_pkg::RGB_W-1:0] held_q, held_d;

  logic accept, restart;
  logic x_last, y_last, pad_col, pad_row, have_pair;
  logic [SW-1:0] ps_r, ps_g, ps_b;
  logic ram_we, ram_re;
  logic [ry420_pkg::LINE_AW-1:0] cidx;
  logic [ry420_pkg::LINE_W-1:0]  ram_rdata;

  // Stage between acceptance and the queue; the line store read lands here.
  logic                         s1_valid_q, s1_valid_d;
  logic [PW-1:0]                s1_r_q, s1_g_q, s1_b_q;
  logic [ry420_pkg::COL_W-1:0]  s1_col_q;
  logic [ry420_pkg::ROW_W-1:0]  s1_row_q;
  logic                         s1_pad_col_q, s1_pad_row_q, s1_chroma_q;
  logic                         s1_from_line_q, s1_frame_end_q;
  logic [SW-1:0]                s1_ps_r_q, s1_ps_g_q, s1_ps_b_q;
  logic [BW-1:0]                sum_r, sum_g, sum_b;

  assign in_ready_o = !s1_valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = s1_valid_q && !full_i;
  assign restart    = cfg_we_i &&
                      (cfg_index_i == ry420_pkg::REG_WIDTH ||
                       cfg_index_i == ry420_pkg::REG_HEIGHT);

  always_comb begin
    eff      = cfg_data_i;
    w_last_d = w_last_q;
    w_odd_d  = w_odd_q;
    h_last_d = h_last_q;
    h_odd_d  = h_odd_q;
    if (cfg_we_i && cfg_index_i == ry420_pkg::REG_WIDTH) begin
      if (cfg_data_i == '0) begin
        eff = ry420_pkg::CFG_W'(1);
      end else if (cfg_data_i > ry420_pkg::CFG_W'(ry420_pkg::WIDTH_LIMIT)) begin
        eff = ry420_pkg::CFG_W'(ry420_pkg::WIDTH_LIMIT);
      end
      w_last_d = ry420_pkg::COL_W'(eff - ry420_pkg::CFG_W'(1));
      w_odd_d  = eff[0];
    end else if (cfg_we_i && cfg_index_i == ry420_pkg::REG_HEIGHT) begin
      if (cfg_data_i == '0) begin
        eff = ry420_pkg::CFG_W'(1);
      end else if (cfg_data_i > ry420_pkg::CFG_W'(ry420_pkg::HEIGHT_LIMIT)) begin
        eff = ry420_pkg::CFG_W'(ry420_pkg::HEIGHT_LIMIT);
      end
      h_last_d = ry420_pkg::ROW_W'(eff - ry420_pkg::CFG_W'(1));
      h_odd_d  = eff[0];
    end
  end

  always_comb begin
    x_last    = (col_q == w_last_q);
    y_last    = (row_q == h_last_q);
    pad_col   = x_last && w_odd_q;
    pad_row   = y_last && h_odd_q;
    have_pair = col_q[0] || pad_col;
    if (col_q[0]) begin
      ps_r = SW'(held_q[23:16]) + SW'(red_i);
      ps_g = SW'(held_q[15:8])  + SW'(green_i);
      ps_b = SW'(held_q[7:0])   + SW'(blue_i);
    end else begin
      ps_r = {red_i, 1'b0};
      ps_g = {green_i, 1'b0};
      ps_b = {blue_i, 1'b0};
    end
    cidx   = ry420_pkg::LINE_AW'(col_q >> 1);
    ram_we = accept && have_pair && !row_q[0] && !pad_row;
    ram_re = accept && have_pair && row_q[0];

    col_d  = col_q;
    row_d  = row_q;
    held_d = held_q;
    if (restart) begin
      col_d  = '0;
      row_d  = '0;
      held_d = '0;
    end else if (accept) begin
      if (x_last) begin
        col_d = '0;
        row_d = y_last ? '0 : ry420_pkg::ROW_W'(row_q + 1'b1);
      end else begin
        col_d = ry420_pkg::COL_W'(col_q + 1'b1);
      end
      if (!have_pair) begin
        held_d = {red_i, green_i, blue_i};
      end
    end

    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (push_o) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q   <= '0;
      w_odd_q    <= 1'b1;
      h_last_q   <= '0;
      h_odd_q    <= 1'b1;
      col_q      <= '0;
      row_q      <= '0;
      held_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      w_last_q   <= w_last_d;
      w_odd_q    <= w_odd_d;
      h_last_q   <= h_last_d;
      h_odd_q    <= h_odd_d;
      col_q      <= col_d;
      row_q      <= row_d;
      held_q     <= held_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_r_q         <= red_i;
      s1_g_q         <= green_i;
      s1_b_q         <= blue_i;
      s1_col_q       <= col_q;
      s1_row_q       <= row_q;
      s1_pad_col_q   <= pad_col;
      s1_pad_row_q   <= pad_row;
      s1_chroma_q    <= have_pair && (row_q[0] || pad_row);
      s1_from_line_q <= row_q[0];
      s1_frame_end_q <= x_last && y_last;
      s1_ps_r_q      <= ps_r;
      s1_ps_g_q      <= ps_g;
      s1_ps_b_q      <= ps_b;
    end
  end

  ry420_ram #(
    .WIDTH (ry420_pkg::LINE_W),
    .DEPTH (ry420_pkg::LINE_DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cidx),
    .wdata_i ({ps_r, ps_g, ps_b}),
    .re_i    (ram_re),
    .raddr_i (cidx),
    .rdata_o (ram_rdata)
  );

  // Block sums: the stored upper pair plus this pair, or this pair doubled
  // when the last row is replicated.
  always_comb begin
    if (s1_from_line_q) begin
      sum_r = BW'(ram_rdata[3*SW-1:2*SW]) + BW'(s1_ps_r_q);
      sum_g = BW'(ram_rdata[2*SW-1:SW])   + BW'(s1_ps_g_q);
      sum_b = BW'(ram_rdata[SW-1:0])      + BW'(s1_ps_b_q);
    end else begin
      sum_r = {s1_ps_r_q, 1'b0};
      sum_g = {s1_ps_g_q, 1'b0};
      sum_b = {s1_ps_b_q, 1'b0};
    end
    entry_o.luma      = ry420_pkg::luma_of(s1_r_q, s1_g_q, s1_b_q);
    entry_o.avg_r     = PW'((sum_r + BW'(2)) >> 2);
    entry_o.avg_g     = PW'((sum_g + BW'(2)) >> 2);
    entry_o.avg_b     = PW'((sum_b + BW'(2)) >> 2);
    entry_o.col       = s1_col_q;
    entry_o.row       = s1_row_q;
    entry_o.pad_col   = s1_pad_col_q;
    entry_o.pad_row   = s1_pad_row_q;
    entry_o.chroma    = s1_chroma_q;
    entry_o.frame_end = s1_frame_end_q;
  end

endmodule

// ===== rtl/ry420_queue.sv =====
// Short FIFO of classified pixel entries between the front and back ends.
// Depends on ry420_pkg.
module ry420_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ry420_pkg::entry_t entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output ry420_pkg::entry_t entry_o,
  output logic              empty_o
);

  localparam int unsigned AW = ry420_pkg::QUEUE_AW;

  ry420_pkg::entry_t slot_q [ry420_pkg::QUEUE_DEPTH];
  logic [AW:0] wptr_q, wptr_d, rptr_q, rptr_d;

  assign empty_o = (wptr_q == rptr_q);
  assign full_o  = (wptr_q[AW-1:0] == rptr_q[AW-1:0]) && (wptr_q[AW] != rptr_q[AW]);
  assign entry_o = slot_q[rptr_q[AW-1:0]];

  always_comb begin
    wptr_d = push_i ? (AW+1)'(wptr_q + 1'b1) : wptr_q;
    rptr_d = pop_i  ? (AW+1)'(rptr_q + 1'b1) : rptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q[AW-1:0]] <= entry_i;
    end
  end

endmodule

// ===== rtl/ry420_back.sv =====
// Back end: takes one entry at a time, forms Cb and Cr, and emits its
// results one per cycle through the output register unless stalled.
// Depends on ry420_pkg.
module ry420_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ry420_pkg::entry_t                 entry_i,
  input  logic                              empty_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ry420_pkg::PLANE_W-1:0]     plane_o,
  output logic [ry420_pkg::COL_W-1:0]       column_o,
  output logic [ry420_pkg::ROW_W-1:0]       row_o,
  output logic [ry420_pkg::PIX_W-1:0]       sample_o,
  output logic                              last_o,
  output logic                              frame_end_o
);

  localparam int unsigned KW = ry420_pkg::KIND_W;

  ry420_pkg::entry_t            work_q;
  logic                         work_valid_q, work_valid_d;
  logic [KW-1:0]                pend_q, pend_d;
  logic [ry420_pkg::PIX_W-1:0]  cb_q, cr_q;

  logic [KW-1:0] sel, rem;
  logic          out_load, done;

  logic                          out_valid_q, out_valid_d;
  logic [ry420_pkg::PLANE_W-1:0] plane_q, plane_d;
  logic [ry420_pkg::COL_W-1:0]   column_q, column_d;
  logic [ry420_pkg::ROW_W-1:0]   row_q, row_d;
  logic [ry420_pkg::PIX_W-1:0]   sample_q, sample_d;
  logic                          last_q, frame_end_q;

  always_comb begin
    sel      = pend_q & (~pend_q + KW'(1));
    rem      = pend_q & ~sel;
    out_load = work_valid_q && (!out_valid_q || out_ready_i);
    done     = out_load && (rem == '0);
    pop_o    = !empty_i && (!work_valid_q || done);

    if (pop_o) begin
      work_valid_d = 1'b1;
      pend_d = {entry_i.chroma, entry_i.chroma, entry_i.pad_row && entry_i.pad_col,
                entry_i.pad_row, entry_i.pad_col, 1'b1};
    end else if (done) begin
      work_valid_d = 1'b0;
      pend_d       = '0;
    end else begin
      work_valid_d = work_valid_q;
      pend_d       = out_load ? rem : pend_q;
    end

    plane_d  = ry420_pkg::PLANE_Y;
    column_d = work_q.col;
    row_d    = work_q.row;
    sample_d = work_q.luma;
    case (sel)
      ry420_pkg::KIND_Y_RIGHT: begin
        column_d = ry420_pkg::COL_W'(work_q.col + 1'b1);
      end
      ry420_pkg::KIND_Y_BELOW: begin
        row_d = ry420_pkg::ROW_W'(work_q.row + 1'b1);
      end
      ry420_pkg::KIND_Y_DIAG: begin
        column_d = ry420_pkg::COL_W'(work_q.col + 1'b1);
        row_d    = ry420_pkg::ROW_W'(work_q.row + 1'b1);
      end
      ry420_pkg::KIND_CB: begin
        plane_d  = ry420_pkg::PLANE_CB;
        column_d = work_q.col >> 1;
        row_d    = work_q.row >> 1;
        sample_d = cb_q;
      end
      ry420_pkg::KIND_CR: begin
        plane_d  = ry420_pkg::PLANE_CR;
        column_d = work_q.col >> 1;
        row_d    = work_q.row >> 1;
        sample_d = cr_q;
      end
      default: begin
        plane_d = ry420_pkg::PLANE_Y;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      work_valid_q <= work_valid_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      work_q <= entry_i;
      cb_q   <= ry420_pkg::cb_of(entry_i.avg_r, entry_i.avg_g, entry_i.avg_b);
      cr_q   <= ry420_pkg::cr_of(entry_i.avg_r, entry_i.avg_g, entry_i.avg_b);
    end
    if (out_load) begin
      plane_q     <= plane_d;
      column_q    <= column_d;
      row_q       <= row_d;
      sample_q    <= sample_d;
      last_q      <= (rem == '0);
      frame_end_q <= (rem == '0) && work_q.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign plane_o     = plane_q;
  assign column_o    = column_q;
  assign row_o       = row_q;
  assign sample_o    = sample_q;
  assign last_o      = last_q;
  assign frame_end_o = frame_end_q;

endmodule

// ===== rtl/rgb_to_ycbcr420_converter.sv =====
// Top level of the RGB to BT.709 limited-range YCbCr 4:2:0 converter.
// Depends on ry420_pkg, ry420_front, ry420_queue and ry420_back.
//
// Usage:
//   Source pixels enter on the in_* channel (valid/ready) in raster order.
//   Each pixel gives one to six results on the out_* channel: luma samples
//   (with replicated padding for an odd last column or row) and, when the
//   pixel completes a 2x2 block, its Cb and Cr. Every result carries plane,
//   column and row; last marks the final result of a pixel and frame_end
//   the final result of the padded frame.
//   source_width (index 0) and source_height (index 1) are written through
//   the cfg_* port while the block is idle; a write restarts the frame.
//   A pixel's first result is registered in turn in the front-end stage, the
//   queue, the back end's work register and the output register. The back end
//   emits one result per cycle while the receiver takes them. A pixel has one
//   result on even source rows and one or three on odd rows away from the
//   padding, 1.5 on average, and up to six at a padded corner.
//   A four-entry queue lets the input keep taking pixels while the output is
//   stalled; when it fills, in_ready_o drops until the receiver takes data.
//   Reset sets both sizes to 1 and the position to the frame start. The line
//   store needs no clearing: every entry is written before it is read.
module rgb_to_ycbcr420_converter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ry420_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ry420_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ry420_pkg::PIX_W-1:0]      red_i,
  input  logic [ry420_pkg::PIX_W-1:0]      green_i,
  input  logic [ry420_pkg::PIX_W-1:0]      blue_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ry420_pkg::PLANE_W-1:0]    plane_o,
  output logic [ry420_pkg::COL_W-1:0]      column_o,
  output logic [ry420_pkg::ROW_W-1:0]      row_o,
  output logic [ry420_pkg::PIX_W-1:0]      sample_o,
  output logic                             last_o,
  output logic                             frame_end_o
);

  ry420_pkg::entry_t push_entry, pop_entry;
  logic              push, pop, full, empty;

  ry420_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  ry420_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .empty_o (empty)
  );

  ry420_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (pop_entry),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .plane_o     (plane_o),
    .column_o    (column_o),
    .row_o       (row_o),
    .sample_o    (sample_o),
    .last_o      (last_o),
    .frame_end_o (frame_end_o)
  );

endmodule
